// ===== hw/rtl/gihs_pkg.sv =====
// Shared types and constants for the gripper I/O handshake sequencer.
package gihs_pkg;

	localparam int unsigned PAT_W   = 6;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned TICK_W  = 17;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

	typedef enum logic [1:0] {
		CMD_SERVO_OFF = 2'd0,
		CMD_RESET     = 2'd1,
		CMD_ORIGIN    = 2'd2,
		CMD_PATTERN   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [PAT_W-1:0] pattern_id;
		logic             busy_in;
	} req_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern_lines;
		logic             setup_line;
		logic             drive_line;
		logic             reset_line;
		logic             servo_line;
		logic             in_progress;
	} rsp_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic             setup;
		logic             drive;
		logic             reset;
		logic             servo;
	} lines_t;

	typedef struct packed {
		logic              servo_on;
		logic              reset_active;
		logic              origin_active;
		logic              pattern_active;
		logic              last_pattern_valid;
		logic [PAT_W-1:0]  last_pattern;
		logic              release_phase;
		logic [TICK_W-1:0] reset_ticks;
		logic [TICK_W-1:0] origin_ticks;
		logic [TICK_W-1:0] pattern_ticks;
		lines_t            lines;
	} seq_state_t;

	localparam seq_state_t STATE_RESET = '0;

endpackage

// ===== hw/rtl/gihs_in_reg.sv =====
// Input stage register: holds one accepted command beat.
module gihs_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  gihs_pkg::req_t  req,
	input  logic            take,
	output logic            valid_s1,
	output gihs_pkg::req_t  req_s1
);

	assign req_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

endmodule

// ===== hw/rtl/gihs_step.sv =====
// Next-state and result logic for one command beat.
module gihs_step (
	input  gihs_pkg::req_t                     req,
	input  gihs_pkg::seq_state_t               cur,
	input  logic [gihs_pkg::LIMIT_W-1:0]       delay_limit,
	output gihs_pkg::seq_state_t               nxt,
	output gihs_pkg::rsp_t                     rsp
);

	logic [gihs_pkg::TICK_W-1:0] limit_x;
	logic [gihs_pkg::TICK_W-1:0] rst_t;
	logic [gihs_pkg::TICK_W-1:0] org_t;
	logic [gihs_pkg::TICK_W-1:0] pat_t;
	logic                        prog;

	assign limit_x = {1'b0, delay_limit};
	assign rst_t   = cur.reset_ticks + 1'b1;
	assign org_t   = cur.origin_ticks + 1'b1;
	assign pat_t   = cur.pattern_ticks + 1'b1;

	always_comb begin
		nxt  = cur;
		prog = 1'b0;
		case (gihs_pkg::cmd_t'(req.cmd))
			gihs_pkg::CMD_SERVO_OFF: begin
				if (cur.servo_on) begin
					nxt.lines.servo = 1'b0;
					nxt.servo_on    = 1'b0;
				end
			end
			gihs_pkg::CMD_RESET: begin
				if (!cur.reset_active) begin
					nxt.lines.pattern = '0;
					nxt.lines.setup   = 1'b0;
					nxt.lines.drive   = 1'b0;
					nxt.lines.reset   = 1'b1;
					nxt.lines.servo   = 1'b1;
					nxt.reset_active  = 1'b1;
					nxt.servo_on      = 1'b1;
				end else if (rst_t > limit_x) begin
					nxt.lines.reset  = 1'b0;
					nxt.reset_active = 1'b0;
					nxt.reset_ticks  = '0;
				end else begin
					nxt.reset_ticks = rst_t;
				end
				prog = nxt.reset_active;
			end
			gihs_pkg::CMD_ORIGIN: begin
				if (!cur.origin_active) begin
					nxt.lines.setup   = 1'b1;
					nxt.origin_active = 1'b1;
				end else if (!req.busy_in) begin
					if (org_t > limit_x) begin
						nxt.lines.setup   = 1'b0;
						nxt.origin_active = 1'b0;
						nxt.origin_ticks  = '0;
					end else begin
						nxt.origin_ticks = org_t;
					end
				end
				prog = nxt.origin_active;
			end
			gihs_pkg::CMD_PATTERN: begin
				if (cur.origin_active) begin
					nxt.lines.setup   = 1'b0;
					nxt.origin_active = 1'b0;
				end
				if (!cur.last_pattern_valid || cur.last_pattern != req.pattern_id) begin
					nxt.last_pattern       = req.pattern_id;
					nxt.last_pattern_valid = 1'b1;
					nxt.lines.pattern      = req.pattern_id;
					nxt.lines.drive        = 1'b1;
					nxt.pattern_active     = 1'b1;
				end else if (!req.busy_in) begin
					if (pat_t > limit_x) begin
						nxt.pattern_ticks = '0;
						if (!cur.release_phase) begin
							nxt.lines.drive   = 1'b0;
							nxt.release_phase = 1'b1;
						end else begin
							nxt.last_pattern_valid = 1'b0;
							nxt.release_phase      = 1'b0;
							nxt.pattern_active     = 1'b0;
						end
					end else begin
						nxt.pattern_ticks = pat_t;
					end
				end
				prog = nxt.pattern_active;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign rsp.pattern_lines = nxt.lines.pattern;
	assign rsp.setup_line    = nxt.lines.setup;
	assign rsp.drive_line    = nxt.lines.drive;
	assign rsp.reset_line    = nxt.lines.reset;
	assign rsp.servo_line    = nxt.lines.servo;
	assign rsp.in_progress   = prog;

endmodule

// ===== hw/rtl/gihs_out_reg.sv =====
// Result register: holds one result beat until the receiver takes it.
module gihs_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  gihs_pkg::rsp_t  rsp_d,
	output logic            free,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gihs_pkg::rsp_t  rsp
);

	assign free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (free) begin
			rsp_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp <= rsp_d;
		end
	end

endmodule

// ===== hw/rtl/gripper_io_handshake_sequencer_core.sv =====
// Top level of the gripper I/O handshake sequencer.
//
// Command beats (cmd, pattern_id, busy_in) come in on req_valid/req_ready;
// one result beat per command (line levels after the update and the
// in_progress flag) leaves on rsp_valid/rsp_ready.
// A command is held in the input register, evaluated there against the
// sequencer state, and its result lands in the result register, which raises
// rsp_valid. One beat per cycle is sustained while rsp_ready stays high.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more command; req_ready then drops until the result is
// taken.
// cfg_we/cfg_wdata write delay_limit; write it only while idle.
// Reset clears all lines, flags and tick counters and sets delay_limit to 500.
module gripper_io_handshake_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  gihs_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output gihs_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [gihs_pkg::LIMIT_W-1:0]  cfg_wdata
);

	logic                         valid_s1;
	gihs_pkg::req_t               req_s1;
	logic                         free;
	logic                         take;
	gihs_pkg::seq_state_t         state_q;
	gihs_pkg::seq_state_t         state_d;
	gihs_pkg::rsp_t               rsp_d;
	logic [gihs_pkg::LIMIT_W-1:0] delay_limit_q;

	assign take = valid_s1 && free;

	gihs_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.take      (take),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	gihs_step u_step (
		.req         (req_s1),
		.cur         (state_q),
		.delay_limit (delay_limit_q),
		.nxt         (state_d),
		.rsp         (rsp_d)
	);

	gihs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.rsp_d     (rsp_d),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gihs_pkg::STATE_RESET;
		end else if (take) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_limit_q <= gihs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			delay_limit_q <= cfg_wdata;
		end
	end

	// servo flag and servo line move together
	a_servo_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.servo_on == state_q.lines.servo)
		else $error("servo flag and servo line differ");

	a_release_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.release_phase |-> state_q.pattern_active)
		else $error("release phase without a running pattern");

	a_reset_ticks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.reset_active |-> state_q.reset_ticks == '0)
		else $error("reset counter non-zero while reset idle");

	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pattern_ticks <= 17'h10000 && state_q.origin_ticks <= 17'h10000)
		else $error("tick counter beyond bound");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

endmodule

// ===== bench/gihs_sequence_checker.sv =====
// Watches the sequencer's command and result channels, predicts each result beat and compares.
`timescale 1ns / 100ps

module gihs_sequence_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  gihs_pkg::req_t                req,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  gihs_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [gihs_pkg::LIMIT_W-1:0]  cfg_wdata,
	output int                            errors,
	output int                            pending
);

	logic [gihs_pkg::LIMIT_W-1:0] limit;
	logic                         servo_on;
	logic                         reset_on;
	logic                         origin_on;
	logic                         pattern_on;
	logic                         held_valid;
	logic [gihs_pkg::PAT_W-1:0]   held_id;
	logic                         releasing;
	logic [gihs_pkg::TICK_W-1:0]  reset_cnt;
	logic [gihs_pkg::TICK_W-1:0]  origin_cnt;
	logic [gihs_pkg::TICK_W-1:0]  pattern_cnt;
	gihs_pkg::lines_t             lines;
	gihs_pkg::rsp_t               line_queue[$];
	int                           bad;

	task automatic advance_sequencer(input gihs_pkg::req_t r, output gihs_pkg::rsp_t res);
		logic running;
		running = 1'b0;
		case (r.cmd)
		gihs_pkg::CMD_SERVO_OFF: begin
			if (servo_on) begin
				lines.servo = 1'b0;
				servo_on = 1'b0;
			end
		end
		gihs_pkg::CMD_RESET: begin
			if (!reset_on) begin
				lines.pattern = '0;
				lines.setup = 1'b0;
				lines.drive = 1'b0;
				lines.reset = 1'b1;
				lines.servo = 1'b1;
				reset_on = 1'b1;
				servo_on = 1'b1;
			end else begin
				reset_cnt = reset_cnt + 1'b1;
				if (reset_cnt > {1'b0, limit}) begin
					lines.reset = 1'b0;
					reset_on = 1'b0;
					reset_cnt = '0;
				end
			end
			running = reset_on;
		end
		gihs_pkg::CMD_ORIGIN: begin
			if (!origin_on) begin
				lines.setup = 1'b1;
				origin_on = 1'b1;
			end else if (!r.busy_in) begin
				origin_cnt = origin_cnt + 1'b1;
				if (origin_cnt > {1'b0, limit}) begin
					lines.setup = 1'b0;
					origin_on = 1'b0;
					origin_cnt = '0;
				end
			end
			running = origin_on;
		end
		gihs_pkg::CMD_PATTERN: begin
			if (origin_on) begin
				lines.setup = 1'b0;
				origin_on = 1'b0;
			end
			if (!held_valid || held_id != r.pattern_id) begin
				held_id = r.pattern_id;
				held_valid = 1'b1;
				lines.pattern = r.pattern_id;
				lines.drive = 1'b1;
				pattern_on = 1'b1;
			end else if (!r.busy_in) begin
				pattern_cnt = pattern_cnt + 1'b1;
				if (pattern_cnt > {1'b0, limit}) begin
					pattern_cnt = '0;
					if (!releasing) begin
						lines.drive = 1'b0;
						releasing = 1'b1;
					end else begin
						held_valid = 1'b0;
						releasing = 1'b0;
						pattern_on = 1'b0;
					end
				end
			end
			running = pattern_on;
		end
		default: begin
			running = 1'b0;
		end
		endcase
		res.pattern_lines = lines.pattern;
		res.setup_line = lines.setup;
		res.drive_line = lines.drive;
		res.reset_line = lines.reset;
		res.servo_line = lines.servo;
		res.in_progress = running;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		gihs_pkg::rsp_t want;
		if (!arst_n) begin
			limit = gihs_pkg::LIMIT_RESET;
			servo_on = 1'b0;
			reset_on = 1'b0;
			origin_on = 1'b0;
			pattern_on = 1'b0;
			held_valid = 1'b0;
			held_id = '0;
			releasing = 1'b0;
			reset_cnt = '0;
			origin_cnt = '0;
			pattern_cnt = '0;
			lines = '0;
			line_queue.delete();
			bad = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (line_queue.size() == 0) begin
					$error("result beat with nothing expected: %h", rsp);
					bad++;
				end else begin
					want = line_queue.pop_front();
					if (rsp.pattern_lines !== want.pattern_lines) begin
						$error("pattern_lines: expected %0d, got %0d",
							want.pattern_lines, rsp.pattern_lines);
						bad++;
					end
					if (rsp.setup_line !== want.setup_line) begin
						$error("setup_line: expected %0b, got %0b",
							want.setup_line, rsp.setup_line);
						bad++;
					end
					if (rsp.drive_line !== want.drive_line) begin
						$error("drive_line: expected %0b, got %0b",
							want.drive_line, rsp.drive_line);
						bad++;
					end
					if (rsp.reset_line !== want.reset_line) begin
						$error("reset_line: expected %0b, got %0b",
							want.reset_line, rsp.reset_line);
						bad++;
					end
					if (rsp.servo_line !== want.servo_line) begin
						$error("servo_line: expected %0b, got %0b",
							want.servo_line, rsp.servo_line);
						bad++;
					end
					if (rsp.in_progress !== want.in_progress) begin
						$error("in_progress: expected %0b, got %0b",
							want.in_progress, rsp.in_progress);
						bad++;
					end
				end
			end
			if (cfg_we)
				limit = cfg_wdata;
			if (req_valid && req_ready) begin
				advance_sequencer(req, want);
				line_queue.push_back(want);
			end
			errors <= bad;
			pending <= line_queue.size();
		end
	end

endmodule

// ===== bench/tb_gripper_io_handshake_sequencer_core.sv =====
// Stimulus, clock, reset and verdict for the gripper I/O handshake sequencer.
`timescale 1ns / 100ps

module tb_gripper_io_handshake_sequencer_core;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_ready;
	gihs_pkg::req_t               req;
	logic                         rsp_valid;
	logic                         rsp_ready;
	gihs_pkg::rsp_t               rsp;
	logic                         cfg_we;
	logic [gihs_pkg::LIMIT_W-1:0] cfg_wdata;
	int                           errors;
	int                           pending;

	int                           sent = 0;
	int                           settings = 1;
	int                           cur_limit = gihs_pkg::LIMIT_RESET;
	bit                           quiet = 1'b0;
	logic [gihs_pkg::PAT_W-1:0]   last_id = '0;

	// opening beats at the reset limit: servo off when off, pattern start and change,
	// origin with and without busy, pattern cutting origin short, reset start over
	// a driven pattern, same id after reset, servo off when on
	gihs_pkg::req_t opening [18] = '{
		'{gihs_pkg::CMD_SERVO_OFF, 6'd0,  1'b0},
		'{gihs_pkg::CMD_PATTERN,   6'd42, 1'b1},
		'{gihs_pkg::CMD_PATTERN,   6'd42, 1'b0},
		'{gihs_pkg::CMD_PATTERN,   6'd21, 1'b0},
		'{gihs_pkg::CMD_ORIGIN,    6'd63, 1'b1},
		'{gihs_pkg::CMD_ORIGIN,    6'd0,  1'b1},
		'{gihs_pkg::CMD_ORIGIN,    6'd0,  1'b0},
		'{gihs_pkg::CMD_PATTERN,   6'd21, 1'b0},
		'{gihs_pkg::CMD_RESET,     6'd63, 1'b1},
		'{gihs_pkg::CMD_RESET,     6'd0,  1'b1},
		'{gihs_pkg::CMD_RESET,     6'd0,  1'b0},
		'{gihs_pkg::CMD_PATTERN,   6'd21, 1'b0},
		'{gihs_pkg::CMD_PATTERN,   6'd63, 1'b1},
		'{gihs_pkg::CMD_ORIGIN,    6'd0,  1'b0},
		'{gihs_pkg::CMD_SERVO_OFF, 6'd0,  1'b0},
		'{gihs_pkg::CMD_SERVO_OFF, 6'd63, 1'b1},
		'{gihs_pkg::CMD_PATTERN,   6'd0,  1'b1},
		'{gihs_pkg::CMD_SERVO_OFF, 6'd63, 1'b1}
	};

	gripper_io_handshake_sequencer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gihs_sequence_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (quiet || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_cmd(input gihs_pkg::req_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_delay_limit(input int value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[gihs_pkg::LIMIT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_limit = value;
		settings++;
	endtask

	// mostly runs of one command of up to 3 * cur_limit + 8 beats (at most 60), some noise
	task automatic random_commands(input int count);
		gihs_pkg::req_t r;
		int             stop;
		int             run;
		int             cap;
		stop = sent + count;
		while (sent < stop) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 7) == 0)
					r.cmd = gihs_pkg::CMD_SERVO_OFF;
				else
					r.cmd = 2'($urandom_range(gihs_pkg::CMD_RESET, gihs_pkg::CMD_PATTERN));
				r.pattern_id = ($urandom_range(0, 2) != 0) ? last_id
					: 6'($urandom_range(0, 63));
				cap = 3 * cur_limit + 8;
				if (cap > 60)
					cap = 60;
				run = $urandom_range(1, cap);
				repeat (run) begin
					r.busy_in = ($urandom_range(0, 4) == 0);
					send_cmd(r);
				end
			end else begin
				r.cmd = 2'($urandom_range(0, 3));
				r.pattern_id = 6'($urandom_range(0, 63));
				r.busy_in = 1'($urandom_range(0, 1));
				send_cmd(r);
			end
			last_id = r.pattern_id;
		end
	endtask

	initial begin : receiver
		int hold;
		hold = 0;
		rsp_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				rsp_ready <= 1'b1;
				hold = $urandom_range(0, 8);
			end else begin
				rsp_ready <= 1'b0;
				hold = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 3);
			end
		end
	end

	initial begin : stimulus
		gihs_pkg::req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			send_cmd(opening[i]);

		set_delay_limit(0);
		random_commands(80);
		set_delay_limit(1);
		random_commands(80);
		quiet = 1'b1;
		set_delay_limit(2);
		random_commands(80);
		quiet = 1'b0;
		set_delay_limit(3);
		random_commands(80);

		// top limit: a reset run that stays well inside the count
		quiet = 1'b1;
		set_delay_limit(16'hFFFF);
		r.cmd = gihs_pkg::CMD_RESET;
		repeat (40) begin
			r.pattern_id = 6'($urandom_range(0, 63));
			r.busy_in = 1'($urandom_range(0, 1));
			send_cmd(r);
		end
		quiet = 1'b0;
		random_commands(40);

		set_delay_limit(gihs_pkg::LIMIT_RESET);
		random_commands(80);
		repeat (3) begin
			set_delay_limit($urandom_range(4, 12));
			random_commands(50);
		end
		drain();

		$display("Sent %0d command beats over %0d delay limit settings (0, 1..12, 500, 65535).",
			sent, settings);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== gripper_io_handshake_sequencer_core.f =====
hw/rtl/gihs_pkg.sv
hw/rtl/gihs_in_reg.sv
hw/rtl/gihs_step.sv
hw/rtl/gihs_out_reg.sv
hw/rtl/gripper_io_handshake_sequencer_core.sv
bench/gihs_sequence_checker.sv
bench/tb_gripper_io_handshake_sequencer_core.sv
